// ----- hdl/ssf_pkg.sv -----
package ssf_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_MAX_RANGE = 2'd0;
  localparam logic [1:0] REG_GAP_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_MIN_POINTS = 2'd2;

  localparam logic [14:0] MAX_RANGE_RESET = 15'd10000;
  localparam logic [15:0] GAP_THRESHOLD_RESET = 16'd100;
  localparam logic [10:0] MIN_POINTS_RESET = 11'd3;

  // shared signed multiplier
  localparam int MUL_W = 18;
  localparam int PROD_W = 36;

  // square root unit: 34-bit radicand, 17-bit root
  localparam int SQ_IN_W = 34;
  localparam int SQ_OUT_W = 17;
  localparam int SQ_REM_W = 20;
  localparam int SQ_STEPS = 17;

  // largest chord cross product fits 34 bits, its square 68
  localparam int CMAX_W = 34;
  localparam int CSQ_W = 68;

  localparam int RES_CNT_W = 11;
  localparam int CONTOUR_W = 20;
  localparam logic [CONTOUR_W-1:0] CONTOUR_MAX = 20'hFFFFF;

  typedef struct packed {
    logic              in_range;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic              scan_end;
  } cmd_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0] point_count;
    logic signed [15:0]   center_x;
    logic signed [15:0]   center_y;
    logic [CONTOUR_W-1:0] contour_len;
    logic [15:0]          chord_width;
    logic [15:0]          depth;
    logic                 last_of_run;
  } result_t;

endpackage

// ----- hdl/ssf_ram.sv -----
module ssf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ssf_isqrt.sv -----
module ssf_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ssf_pkg::SQ_IN_W-1:0] radicand,
  output logic [ssf_pkg::SQ_OUT_W-1:0] root,
  output logic                        done
);

  localparam int STEP_W = $clog2(ssf_pkg::SQ_STEPS + 1);

  logic                         busy;
  logic [STEP_W-1:0]            step;
  logic [ssf_pkg::SQ_IN_W-1:0]  val;
  logic [ssf_pkg::SQ_REM_W-1:0] rem;
  logic [ssf_pkg::SQ_REM_W-1:0] remsh;
  logic [ssf_pkg::SQ_REM_W-1:0] trial;

  assign remsh = {rem[ssf_pkg::SQ_REM_W-3:0], val[ssf_pkg::SQ_IN_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  // one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        val  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        if (remsh >= trial) begin
          rem  <= remsh - trial;
          root <= {root[ssf_pkg::SQ_OUT_W-2:0], 1'b1};
        end else begin
          rem  <= remsh;
          root <= {root[ssf_pkg::SQ_OUT_W-2:0], 1'b0};
        end
        val  <= {val[ssf_pkg::SQ_IN_W-3:0], 2'b00};
        step <= step + 1'b1;
        if (step == STEP_W'(ssf_pkg::SQ_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/ssf_front.sv -----
module ssf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        range_mm,
  input  logic signed [15:0] x_mm,
  input  logic signed [15:0] y_mm,
  input  logic               scan_end,
  input  logic [14:0]        max_range,
  input  logic               cmd_pop,
  output logic               cmd_valid,
  output ssf_pkg::cmd_t      cmd
);

  ssf_pkg::cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[rp];
  assign do_push = push && !full;
  assign do_pop = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp].in_range <= (range_mm < {1'b0, max_range});
      q[wp].x <= x_mm;
      q[wp].y <= y_mm;
      q[wp].scan_end <= scan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/ssf_back.sv -----
module ssf_back #(
  parameter int MAX_POINTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  ssf_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  logic [15:0]        gap_threshold,
  input  logic [10:0]        min_points,
  output logic               res_empty,
  input  logic               res_pop,
  output ssf_pkg::result_t   res
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = CNT_W + 1;
  localparam int SUM_W = 16 + $clog2(MAX_POINTS);
  localparam int MUL_W = ssf_pkg::MUL_W;
  localparam int PROD_W = ssf_pkg::PROD_W;
  localparam int SQ_IN_W = ssf_pkg::SQ_IN_W;
  localparam int CMAX_W = ssf_pkg::CMAX_W;
  localparam int CSQ_W = ssf_pkg::CSQ_W;
  localparam int HALF_W = CMAX_W / 2;

  typedef enum logic [4:0] {
    S_IDLE, S_DX, S_DY, S_DG, S_DJ, S_POST, S_SQC, S_APPEND, S_ENDCHK, S_FINISH,
    C_BEGIN, C_FIRST, C_LX, C_LY, C_L2, C_WSQ, C_RD, C_PT, C_MA, C_MB, C_CMP,
    C_S0, C_S1, C_S2, C_S3, C_DV, C_DSQW, C_CENP, C_CEN, C_EMIT
  } state_t;

  state_t state;
  state_t ret;

  ssf_pkg::cmd_t cmd_r;
  logic [CNT_W-1:0]              count;
  logic [ssf_pkg::CONTOUR_W-1:0] contour;
  logic signed [SUM_W-1:0]       sum_x;
  logic signed [SUM_W-1:0]       sum_y;
  logic signed [15:0]            prev_x;
  logic signed [15:0]            prev_y;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic [SQ_IN_W-1:0] acc;
  logic [SQ_IN_W-1:0] d2;
  logic [SQ_IN_W-1:0] l2;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [16:0] ux;
  logic signed [16:0] uy;
  logic signed [16:0] vx;
  logic signed [16:0] vy;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [PROD_W-1:0] t1;
  logic [PROD_W:0]    cr;
  logic [PROD_W:0]    mag;
  logic [CMAX_W-1:0]  cmax;
  logic [CSQ_W-1:0]   csq;
  logic [SQ_IN_W-1:0] rem;
  logic [SQ_IN_W:0]   remsh;
  logic [SQ_IN_W-1:0] quot;
  logic               qbit;
  logic [AW-1:0]      idx;
  logic [6:0]         step;
  logic [15:0]        width;
  logic [15:0]        depth_r;

  logic [SUM_W-1:0] nx;
  logic [SUM_W-1:0] ny;
  logic [CNT_W-1:0] rx;
  logic [CNT_W-1:0] ry;
  logic [CNT_W:0]   rxsh;
  logic [CNT_W:0]   rysh;
  logic             sx_neg;
  logic             sy_neg;
  logic [SUM_W-1:0] cx_full;
  logic [SUM_W-1:0] cy_full;

  logic                       sq_start;
  logic [SQ_IN_W-1:0]         sq_arg;
  logic [ssf_pkg::SQ_OUT_W-1:0] sq_root;
  logic                       sq_done;
  logic [15:0]                sq_clamp;
  logic [ssf_pkg::CONTOUR_W:0] contour_sum;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic signed [15:0] rd_x;
  logic signed [15:0] rd_y;

  logic count_lt_max;
  logic joins;

  ssf_pkg::result_t pend;
  logic             pend_v;
  ssf_pkg::result_t new_res;
  ssf_pkg::result_t ofifo [2];
  logic             owp;
  logic             orp;
  logic [1:0]       ocnt;
  logic             out_room;
  logic             opush;
  logic             opop;
  ssf_pkg::result_t opush_data;

  assign rd_x = ram_rdata[15:0];
  assign rd_y = ram_rdata[31:16];
  assign dx = {cmd_r.x[15], cmd_r.x} - {prev_x[15], prev_x};
  assign dy = {cmd_r.y[15], cmd_r.y} - {prev_y[15], prev_y};
  assign count_lt_max = (count < CNT_W'(MAX_POINTS));
  assign joins = cmd_r.in_range && count_lt_max && (d2 < mul_p[SQ_IN_W-1:0]);
  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign ram_we = (state == S_APPEND) && cmd_r.in_range && count_lt_max;
  assign ram_raddr = (state == C_RD) ? idx : '0;

  assign cr = {t1[PROD_W-1], t1} - {mul_p[PROD_W-1], mul_p};
  assign mag = cr[PROD_W] ? (~cr + 1'b1) : cr;
  assign remsh = {rem, csq[CSQ_W-1]};
  assign qbit = (remsh >= {1'b0, l2});
  assign rxsh = {rx, nx[SUM_W-1]};
  assign rysh = {ry, ny[SUM_W-1]};
  assign sq_clamp = sq_root[ssf_pkg::SQ_OUT_W-1] ? 16'hFFFF : sq_root[15:0];
  assign contour_sum = {1'b0, contour} + (ssf_pkg::CONTOUR_W + 1)'(sq_root);
  assign cx_full = sx_neg ? (~nx + 1'b1) : nx;
  assign cy_full = sy_neg ? (~ny + 1'b1) : ny;

  always_comb begin
    new_res.point_count = ssf_pkg::RES_CNT_W'(count);
    new_res.center_x    = cx_full[15:0];
    new_res.center_y    = cy_full[15:0];
    new_res.contour_len = contour;
    new_res.chord_width = width;
    new_res.depth       = depth_r;
    new_res.last_of_run = 1'b0;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DX: begin
        mul_a = {dx[16], dx};
        mul_b = {dx[16], dx};
      end
      S_DY: begin
        mul_a = {dy[16], dy};
        mul_b = {dy[16], dy};
      end
      S_DG: begin
        mul_a = {2'b00, gap_threshold};
        mul_b = {2'b00, gap_threshold};
      end
      C_LX: begin
        mul_a = {ux[16], ux};
        mul_b = {ux[16], ux};
      end
      C_LY: begin
        mul_a = {uy[16], uy};
        mul_b = {uy[16], uy};
      end
      C_MA: begin
        mul_a = {ux[16], ux};
        mul_b = {vy[16], vy};
      end
      C_MB: begin
        mul_a = {uy[16], uy};
        mul_b = {vx[16], vx};
      end
      C_S0: begin
        mul_a = {1'b0, cmax[CMAX_W-1:HALF_W]};
        mul_b = {1'b0, cmax[CMAX_W-1:HALF_W]};
      end
      C_S1: begin
        mul_a = {1'b0, cmax[CMAX_W-1:HALF_W]};
        mul_b = {1'b0, cmax[HALF_W-1:0]};
      end
      C_S2: begin
        mul_a = {1'b0, cmax[HALF_W-1:0]};
        mul_b = {1'b0, cmax[HALF_W-1:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign out_room = (ocnt != 2'd2);
  assign opop = res_pop && (ocnt != 2'd0);
  assign opush = pend_v && out_room && ((state == S_FINISH) || (state == C_EMIT));

  always_comb begin
    opush_data = pend;
    opush_data.last_of_run = (state == S_FINISH);
  end

  assign res_empty = (ocnt == 2'd0);
  assign res = ofifo[orp];

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo[owp] <= opush_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (opush) begin
        owp <= ~owp;
      end
      if (opop) begin
        orp <= ~orp;
      end
      if (opush && !opop) begin
        ocnt <= ocnt + 2'd1;
      end else if (opop && !opush) begin
        ocnt <= ocnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_FINISH;
      count    <= '0;
      contour  <= '0;
      sum_x    <= '0;
      sum_y    <= '0;
      prev_x   <= '0;
      prev_y   <= '0;
      pend_v   <= 1'b0;
      sq_start <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            state <= (count != '0) ? S_DX : S_POST;
          end
        end
        S_DX: state <= S_DY;
        S_DY: begin
          acc   <= mul_p[SQ_IN_W-1:0];
          state <= S_DG;
        end
        S_DG: begin
          d2    <= acc + mul_p[SQ_IN_W-1:0];
          state <= S_DJ;
        end
        S_DJ: begin
          if (!joins) begin
            ret   <= S_POST;
            state <= C_BEGIN;
          end else begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (cmd_r.in_range) begin
            if (count != '0) begin
              sq_arg   <= d2;
              sq_start <= 1'b1;
              state    <= S_SQC;
            end else begin
              state <= S_APPEND;
            end
          end else begin
            state <= S_ENDCHK;
          end
        end
        S_SQC: begin
          if (sq_done) begin
            contour <= contour_sum[ssf_pkg::CONTOUR_W]
                       ? ssf_pkg::CONTOUR_MAX : contour_sum[ssf_pkg::CONTOUR_W-1:0];
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (count_lt_max) begin
            count <= count + 1'b1;
          end
          sum_x  <= sum_x + {{(SUM_W-16){cmd_r.x[15]}}, cmd_r.x};
          sum_y  <= sum_y + {{(SUM_W-16){cmd_r.y[15]}}, cmd_r.y};
          prev_x <= cmd_r.x;
          prev_y <= cmd_r.y;
          state  <= S_ENDCHK;
        end
        S_ENDCHK: begin
          if (cmd_r.scan_end && (count != '0)) begin
            ret   <= S_FINISH;
            state <= C_BEGIN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (out_room) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        C_BEGIN: begin
          if ((count != '0) && (32'(count) >= 32'(min_points))) begin
            state <= C_FIRST;
          end else begin
            count   <= '0;
            contour <= '0;
            sum_x   <= '0;
            sum_y   <= '0;
            state   <= ret;
          end
        end
        C_FIRST: begin
          ax    <= rd_x;
          ay    <= rd_y;
          ux    <= {prev_x[15], prev_x} - {rd_x[15], rd_x};
          uy    <= {prev_y[15], prev_y} - {rd_y[15], rd_y};
          state <= C_LX;
        end
        C_LX: state <= C_LY;
        C_LY: begin
          acc   <= mul_p[SQ_IN_W-1:0];
          state <= C_L2;
        end
        C_L2: begin
          l2       <= acc + mul_p[SQ_IN_W-1:0];
          sq_arg   <= acc + mul_p[SQ_IN_W-1:0];
          sq_start <= 1'b1;
          state    <= C_WSQ;
        end
        C_WSQ: begin
          if (sq_done) begin
            width <= sq_clamp;
            cmax  <= '0;
            idx   <= AW'(1);
            if ((l2 != '0) && (count >= CNT_W'(3))) begin
              state <= C_RD;
            end else begin
              depth_r <= '0;
              state   <= C_CENP;
            end
          end
        end
        C_RD: state <= C_PT;
        C_PT: begin
          vx    <= {rd_x[15], rd_x} - {ax[15], ax};
          vy    <= {rd_y[15], rd_y} - {ay[15], ay};
          state <= C_MA;
        end
        C_MA: state <= C_MB;
        C_MB: begin
          t1    <= mul_p;
          state <= C_CMP;
        end
        C_CMP: begin
          if (mag > (PROD_W + 1)'(cmax)) begin
            cmax <= mag[CMAX_W-1:0];
          end
          if ((CMP_W'(idx) + CMP_W'(2)) < CMP_W'(count)) begin
            idx   <= idx + 1'b1;
            state <= C_RD;
          end else begin
            state <= C_S0;
          end
        end
        C_S0: state <= C_S1;
        C_S1: begin
          csq   <= {mul_p[CMAX_W-1:0], {CMAX_W{1'b0}}};
          state <= C_S2;
        end
        C_S2: begin
          csq   <= csq + (CSQ_W'(mul_p[CMAX_W-1:0]) << (HALF_W + 1));
          state <= C_S3;
        end
        C_S3: begin
          csq   <= csq + CSQ_W'(mul_p[CMAX_W-1:0]);
          rem   <= '0;
          quot  <= '0;
          step  <= '0;
          state <= C_DV;
        end
        C_DV: begin
          // squared cross product over squared chord, one quotient bit a cycle
          rem  <= qbit ? SQ_IN_W'(remsh - {1'b0, l2}) : remsh[SQ_IN_W-1:0];
          quot <= {quot[SQ_IN_W-2:0], qbit};
          csq  <= {csq[CSQ_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == 7'(CSQ_W - 1)) begin
            sq_arg   <= {quot[SQ_IN_W-2:0], qbit};
            sq_start <= 1'b1;
            state    <= C_DSQW;
          end
        end
        C_DSQW: begin
          if (sq_done) begin
            depth_r <= sq_clamp;
            state   <= C_CENP;
          end
        end
        C_CENP: begin
          sx_neg <= sum_x[SUM_W-1];
          sy_neg <= sum_y[SUM_W-1];
          nx     <= sum_x[SUM_W-1] ? (~sum_x + 1'b1) : sum_x;
          ny     <= sum_y[SUM_W-1] ? (~sum_y + 1'b1) : sum_y;
          rx     <= '0;
          ry     <= '0;
          step   <= '0;
          state  <= C_CEN;
        end
        C_CEN: begin
          if (rxsh >= {1'b0, count}) begin
            rx <= CNT_W'(rxsh - {1'b0, count});
            nx <= {nx[SUM_W-2:0], 1'b1};
          end else begin
            rx <= rxsh[CNT_W-1:0];
            nx <= {nx[SUM_W-2:0], 1'b0};
          end
          if (rysh >= {1'b0, count}) begin
            ry <= CNT_W'(rysh - {1'b0, count});
            ny <= {ny[SUM_W-2:0], 1'b1};
          end else begin
            ry <= rysh[CNT_W-1:0];
            ny <= {ny[SUM_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == 7'(SUM_W - 1)) begin
            state <= C_EMIT;
          end
        end
        C_EMIT: begin
          // hold until the earlier pending beat can leave
          if (!pend_v || out_room) begin
            pend    <= new_res;
            pend_v  <= 1'b1;
            count   <= '0;
            contour <= '0;
            sum_x   <= '0;
            sum_y   <= '0;
            state   <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ssf_ram #(
    .WIDTH(32),
    .DEPTH(MAX_POINTS)
  ) u_points (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata({cmd_r.y, cmd_r.x}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ssf_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .radicand(sq_arg),
    .root    (sq_root),
    .done    (sq_done)
  );

endmodule

// ----- hdl/scan_segment_features.sv -----
// Scan segmentation: one scan point per input beat (range_mm, x_mm, y_mm,
// scan_end), written with push while full is low. Segment reports leave on
// the result side: while empty is low the oldest report is on the ports and
// pop takes it. last_of_run marks the final report caused by one point.
// Registers max_range, gap_threshold and min_points sit on the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// A two-entry input queue feeds a sequencer built around one shared
// 18x18 multiplier and a 17-step bit-serial square root. A point with no
// segment open skips the gap test, which a point with a segment open takes
// first; a joining point also takes a square root for the contour length.
// Closing an unreported segment only clears it; a reported one takes a root
// for the chord width, then for the depth a cross product per interior
// point, the square of the largest one, the division and its root, and then
// the centroid division. At reset all segment state clears at once
// (the point memory needs no clearing) and the registers take 10000, 100
// and 3. A stalled receiver backs up the two-entry result queue; the
// sequencer then waits and the input queue fills and raises full.
module scan_segment_features #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ssf_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssf_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic [15:0]                  range_mm,
  input  logic signed [15:0]           x_mm,
  input  logic signed [15:0]           y_mm,
  input  logic                         scan_end,
  output logic                         empty,
  input  logic                         pop,
  output logic [10:0]                  point_count,
  output logic signed [15:0]           center_x,
  output logic signed [15:0]           center_y,
  output logic [19:0]                  contour_len,
  output logic [15:0]                  chord_width,
  output logic [15:0]                  depth,
  output logic                         last_of_run
);

  logic [14:0] max_range;
  logic [15:0] gap_threshold;
  logic [10:0] min_points;
  logic        cfg_wr;
  logic        cmd_valid;
  logic        cmd_pop;
  ssf_pkg::cmd_t    cmd;
  ssf_pkg::result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range     <= ssf_pkg::MAX_RANGE_RESET;
      gap_threshold <= ssf_pkg::GAP_THRESHOLD_RESET;
      min_points    <= ssf_pkg::MIN_POINTS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ssf_pkg::REG_MAX_RANGE:     max_range <= pwdata[14:0];
        ssf_pkg::REG_GAP_THRESHOLD: gap_threshold <= pwdata[15:0];
        ssf_pkg::REG_MIN_POINTS:    min_points <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ssf_pkg::REG_MAX_RANGE:     prdata = {17'd0, max_range};
      ssf_pkg::REG_GAP_THRESHOLD: prdata = {16'd0, gap_threshold};
      ssf_pkg::REG_MIN_POINTS:    prdata = {21'd0, min_points};
      default:                    prdata = '0;
    endcase
  end

  ssf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .range_mm (range_mm),
    .x_mm     (x_mm),
    .y_mm     (y_mm),
    .scan_end (scan_end),
    .max_range(max_range),
    .cmd_pop  (cmd_pop),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  ssf_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .gap_threshold(gap_threshold),
    .min_points   (min_points),
    .res_empty    (empty),
    .res_pop      (pop),
    .res          (res)
  );

  assign point_count = res.point_count;
  assign center_x    = res.center_x;
  assign center_y    = res.center_y;
  assign contour_len = res.contour_len;
  assign chord_width = res.chord_width;
  assign depth       = res.depth;
  assign last_of_run = res.last_of_run;

endmodule
